// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge, reset included
`define CBT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// checked only while out of reset
`define CBT_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/cbt_pkg.sv =====
`timescale 1ns / 1ps

package cbt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;

    typedef struct packed {
        logic action;
        logic [7:0] text_byte;
    } item_t;

    typedef struct packed {
        logic valid;
        logic [1:0] token_kind;
        logic [7:0] data_byte;
    } token_t;

    typedef struct packed {
        logic inside_quotes;
        logic quote_pending;
        logic after_carriage_return;
        logic field_has_data;
        logic row_has_fields;
    } flags_t;

endpackage

// ===== rtl/cbt_in_stage.sv =====
`timescale 1ns / 1ps

module cbt_in_stage
    import cbt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  held_valid,
    output item_t held_item,
    input  logic  advance
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // room when empty or when the held word leaves this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ===== rtl/cbt_step_logic.sv =====
`timescale 1ns / 1ps

module cbt_step_logic
    import cbt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   step,
    input  item_t  item,
    output token_t token
);

    flags_t flags_reg;
    flags_t flags_next;
    flags_t f;
    token_t tok;
    logic [7:0] c;

    assign c = item.text_byte;

    always_comb
    begin
        f   = flags_reg;
        tok = '0;
        if (item.action == ACT_END)
        begin
            f = '0;
            if (flags_reg.field_has_data || flags_reg.row_has_fields)
            begin
                tok.valid      = 1'b1;
                tok.token_kind = KIND_ROW;
            end
        end
        else if (flags_reg.after_carriage_return && c == CH_LF)
        begin
            // lf of a cr-lf pair is swallowed
            f.after_carriage_return = 1'b0;
        end
        else
        begin
            f.after_carriage_return = 1'b0;
            if (flags_reg.quote_pending && c == CH_QUOTE)
            begin
                // doubled quote inside quotes
                f.quote_pending  = 1'b0;
                f.field_has_data = 1'b1;
                tok.valid        = 1'b1;
                tok.token_kind   = KIND_DATA;
                tok.data_byte    = CH_QUOTE;
            end
            else
            begin
                if (flags_reg.quote_pending)
                begin
                    f.quote_pending = 1'b0;
                    f.inside_quotes = 1'b0;
                end
                if (c == CH_QUOTE)
                begin
                    if (f.inside_quotes)
                    begin
                        f.quote_pending = 1'b1;
                    end
                    else
                    begin
                        f.inside_quotes = 1'b1;
                    end
                end
                else if (!f.inside_quotes && c == CH_COMMA)
                begin
                    f.field_has_data = 1'b0;
                    f.row_has_fields = 1'b1;
                    tok.valid        = 1'b1;
                    tok.token_kind   = KIND_FIELD;
                end
                else if (!f.inside_quotes && (c == CH_CR || c == CH_LF))
                begin
                    f.field_has_data        = 1'b0;
                    f.row_has_fields        = 1'b0;
                    f.after_carriage_return = (c == CH_CR);
                    tok.valid               = 1'b1;
                    tok.token_kind          = KIND_ROW;
                end
                else
                begin
                    f.field_has_data = 1'b1;
                    tok.valid        = 1'b1;
                    tok.token_kind   = KIND_DATA;
                    tok.data_byte    = c;
                end
            end
        end
    end

    assign flags_next = step ? f : flags_reg;
    assign token      = tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

endmodule

// ===== rtl/cbt_out_stage.sv =====
`timescale 1ns / 1ps

module cbt_out_stage
    import cbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  token_t     token,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [1:0] kind_reg;
    logic [7:0] data_reg;

    assign room       = !valid_reg || out_ready;
    assign valid_next = (load && token.valid) ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && token.valid)
        begin
            kind_reg <= token.token_kind;
            data_reg <= token.data_byte;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/csv_byte_tokenizer_core.sv =====
`timescale 1ns / 1ps

// CSV tokenizer: one text byte (or an end-of-input word) per cycle in, at most
// one token out per word. A word is registered in the input stage, run through
// the quote/comma/line-end flag logic and lands in the output register; the
// block keeps up with one word every cycle for as long as the output side
// takes them. Quotes other than the second of a doubled pair, a swallowed lf
// after cr and an end of input with nothing open produce no output word.
// After end of input all flags are back at their reset values.
module csv_byte_tokenizer_core
    import cbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tuser,   // [0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] m_axis_tuser    // [1:0] token_kind
);

    item_t  in_item;
    item_t  held_item;
    logic   held_valid;
    logic   room;
    logic   advance;
    token_t token;

    assign in_item.action    = s_axis_tuser;
    assign in_item.text_byte = s_axis_tdata;

    // a held word moves on whenever the output register can take its token
    assign advance = held_valid && room;

    cbt_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .advance    (advance)
    );

    cbt_step_logic u_step
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (held_item),
        .token (token)
    );

    cbt_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .token     (token),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/cbt_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbt_checker
    import cbt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    // reset clears the output valid register
    `CBT_ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |=> !m_axis_tvalid, "output valid in reset")

    `CBT_ASSERT_RUN(a_kind_legal, clk, rst_n,
        m_axis_tvalid |-> (m_axis_tuser == KIND_DATA || m_axis_tuser == KIND_FIELD ||
                           m_axis_tuser == KIND_ROW),
        "bad token kind")

    `CBT_ASSERT_RUN(a_marks_no_data, clk, rst_n,
        (m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> m_axis_tdata == 8'd0,
        "data on field or row mark")

    `CBT_ASSERT_RUN(a_out_hold, clk, rst_n,
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)),
        "stalled token changed")

    // the input only waits while a token sits in a stalled output
    `CBT_ASSERT_RUN(a_stall_only_when_full, clk, rst_n,
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready),
        "input stalled with free output")

endmodule

bind csv_byte_tokenizer_core cbt_checker u_cbt_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
